// ===== hdl/rbt_pkg.sv =====
package rbt_pkg;

   localparam int TABLE_ENTRIES = 64;

   localparam logic [2:0] OP_TEXTURE = 3'd0;
   localparam logic [2:0] OP_BUFFER  = 3'd1;
   localparam logic [2:0] OP_ASSUME  = 3'd2;
   localparam logic [2:0] OP_DELETE  = 3'd3;
   localparam logic [2:0] OP_CLEAR   = 3'd4;

   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_DISCARD_READ = 2'd1;
   localparam logic [1:0] ST_FULL         = 2'd2;

   localparam logic [3:0] LAYOUT_UNDEF = 4'd0;
   localparam logic [3:0] LAYOUT_UAV   = 4'd6;
   localparam logic [1:0] ACC_NONE     = 2'd0;
   localparam logic [1:0] ACC_READ     = 2'd1;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] resource_id;
      logic [3:0]  target_layout;
      logic [1:0]  access_kind;
      logic [7:0]  stage_bits;
      logic [3:0]  present_layout;
      logic        discardable;
   } req_payload_type;

   typedef struct packed {
      logic        barrier;
      logic [15:0] barrier_resource;
      logic [3:0]  from_layout;
      logic [3:0]  to_layout;
      logic [1:0]  from_access;
      logic [1:0]  to_access;
      logic [7:0]  from_stages;
      logic [7:0]  to_stages;
      logic [1:0]  status;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] id;
      logic [3:0]  layout;
      logic [1:0]  access;
      logic [7:0]  stages;
   } entry_type;

   // token that walks the cell row with the request in progress
   typedef struct packed {
      logic            active;
      logic            done;
      logic            shift;
      rsp_payload_type result;
   } token_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_DRAIN
   } fsm_state_type;

endpackage

// ===== hdl/rbt_req_if.sv =====
interface rbt_req_if import rbt_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rbt_rsp_if.sv =====
interface rbt_rsp_if import rbt_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rbt_cell.sv =====
module rbt_cell import rbt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type cmd,
   input  token_type       tok_prev,
   input  logic            next_valid,
   input  entry_type       next_entry,
   output token_type       tok_next,
   output logic            valid_out,
   output entry_type       entry_out
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   token_type tok_ff, tok_in;
   logic      hit, rw, need_bar;

   always_comb begin
      hit      = valid_ff && (entry_ff.id == cmd.resource_id);
      rw       = (cmd.access_kind != ACC_READ) || (entry_ff.access != ACC_READ);
      need_bar = (entry_ff.layout != cmd.target_layout) ||
                 ((cmd.target_layout == LAYOUT_UAV) && rw);
      valid_in = valid_ff;
      entry_in = entry_ff;
      tok_in   = tok_prev;
      if (tok_prev.active && !tok_prev.done) begin
         case (cmd.opcode) inside
            OP_TEXTURE, OP_BUFFER, OP_ASSUME: begin
               if (hit) begin
                  tok_in.done     = 1'b1;
                  entry_in.access = cmd.access_kind;
                  if (cmd.opcode == OP_ASSUME) begin
                     entry_in.layout = cmd.target_layout;
                     entry_in.stages = cmd.stage_bits;
                  end else if (cmd.opcode == OP_TEXTURE) begin
                     entry_in.layout = cmd.target_layout;
                     entry_in.stages = entry_ff.stages | cmd.stage_bits;
                     if (need_bar) begin
                        tok_in.result.barrier          = 1'b1;
                        tok_in.result.barrier_resource = cmd.resource_id;
                        tok_in.result.from_layout      = entry_ff.layout;
                        tok_in.result.to_layout        = cmd.target_layout;
                        tok_in.result.from_access      = entry_ff.access;
                        tok_in.result.to_access        = cmd.access_kind;
                        tok_in.result.from_stages      = entry_ff.stages;
                        tok_in.result.to_stages        = cmd.stage_bits;
                        entry_in.stages                = cmd.stage_bits;
                     end
                  end else begin
                     entry_in.stages = entry_ff.stages | cmd.stage_bits;
                     if (rw) begin
                        tok_in.result.barrier          = 1'b1;
                        tok_in.result.barrier_resource = cmd.resource_id;
                        tok_in.result.from_layout      = LAYOUT_UNDEF;
                        tok_in.result.to_layout        = LAYOUT_UNDEF;
                        tok_in.result.from_access      = entry_ff.access;
                        tok_in.result.to_access        = cmd.access_kind;
                        tok_in.result.from_stages      = entry_ff.stages;
                        tok_in.result.to_stages        = cmd.stage_bits;
                        entry_in.stages                = cmd.stage_bits;
                     end
                  end
               end else if (!valid_ff) begin
                  // entries stay packed at the low end, so a free cell means a miss
                  tok_in.done     = 1'b1;
                  valid_in        = 1'b1;
                  entry_in.id     = cmd.resource_id;
                  entry_in.layout = (cmd.opcode == OP_BUFFER) ? LAYOUT_UNDEF
                                                              : cmd.target_layout;
                  entry_in.access = cmd.access_kind;
                  entry_in.stages = cmd.stage_bits;
                  if (cmd.opcode == OP_TEXTURE) begin
                     if (cmd.discardable && (cmd.access_kind == ACC_READ)) begin
                        tok_in.result.status = ST_DISCARD_READ;
                     end else begin
                        tok_in.result.barrier          = 1'b1;
                        tok_in.result.barrier_resource = cmd.resource_id;
                        tok_in.result.from_layout      = cmd.discardable ? LAYOUT_UNDEF
                                                                         : cmd.present_layout;
                        tok_in.result.to_layout        = cmd.target_layout;
                        tok_in.result.from_access      = ACC_NONE;
                        tok_in.result.to_access        = cmd.access_kind;
                        tok_in.result.from_stages      = 8'd0;
                        tok_in.result.to_stages        = cmd.stage_bits;
                     end
                  end
               end
            end
            OP_DELETE: begin
               // pull the upper neighbor down over the removed entry
               if (tok_prev.shift || hit) begin
                  tok_in.shift = 1'b1;
                  valid_in     = next_valid;
                  entry_in     = next_entry;
               end
            end
            OP_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         tok_ff.active <= tok_in.active;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff      <= entry_in;
      tok_ff.done   <= tok_in.done;
      tok_ff.shift  <= tok_in.shift;
      tok_ff.result <= tok_in.result;
   end

   assign tok_next  = tok_ff;
   assign valid_out = valid_ff;
   assign entry_out = entry_ff;

endmodule

// ===== hdl/resource_barrier_tracker.sv =====
// The request token is registered on accept, walks the row of table cells one cell per
// cycle, and its result is captured in the result register and then in the response
// register; an earlier response still waiting for ready holds the result back.
// Only one request is in flight: the next request is taken once the result has moved
// to the response register, even while that response waits.
// Reset (synchronous, active high) empties the table and drops any pending response.
module resource_barrier_tracker import rbt_pkg::*; (
   input logic      clock,
   input logic      reset,
   rbt_req_if.sink  req_port,
   rbt_rsp_if.source rsp_port
);

   fsm_state_type   state_ff, state_in;
   req_payload_type cmd_ff;
   token_type       inj_ff, inj_in;
   rsp_payload_type res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   logic            req_accept, rsp_load;

   token_type       tok_chain [TABLE_ENTRIES+1];
   logic            valid_chain [TABLE_ENTRIES+1];
   entry_type       entry_chain [TABLE_ENTRIES+1];

   assign req_accept = req_port.valid && req_port.ready;

   always_comb begin
      inj_in        = '0;
      inj_in.active = req_accept;
   end

   assign tok_chain[0]                = inj_ff;
   assign valid_chain[TABLE_ENTRIES]  = 1'b0;
   assign entry_chain[TABLE_ENTRIES]  = '0;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      rbt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd_ff),
         .tok_prev   (tok_chain[i]),
         .next_valid (valid_chain[i+1]),
         .next_entry (entry_chain[i+1]),
         .tok_next   (tok_chain[i+1]),
         .valid_out  (valid_chain[i]),
         .entry_out  (entry_chain[i])
      );
   end

   // a request that walked past the last cell without a slot hits a full table
   always_comb begin
      res_in = tok_chain[TABLE_ENTRIES].result;
      case (cmd_ff.opcode) inside
         OP_TEXTURE, OP_BUFFER, OP_ASSUME: begin
            if (!tok_chain[TABLE_ENTRIES].done) begin
               res_in        = '0;
               res_in.status = ST_FULL;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE:  if (req_accept) state_in = FSM_WALK;
         FSM_WALK:  if (tok_chain[TABLE_ENTRIES].active) state_in = FSM_DRAIN;
         FSM_DRAIN: if (!rsp_valid_ff || rsp_port.ready) state_in = FSM_IDLE;
         default:   state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_port.ready = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         FSM_IDLE:  req_port.ready = 1'b1;
         FSM_WALK:  ;
         FSM_DRAIN: rsp_load = !rsp_valid_ff || rsp_port.ready;
         default:   ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         inj_ff.active <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         inj_ff.active <= inj_in.active;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inj_ff.done   <= inj_in.done;
      inj_ff.shift  <= inj_in.shift;
      inj_ff.result <= inj_in.result;
      if (req_accept) begin
         cmd_ff <= req_port.data;
      end
      if (tok_chain[TABLE_ENTRIES].active) begin
         res_ff <= res_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.data  = rsp_data_ff;

endmodule

// ===== hdl/rbt_checker.sv =====
module rbt_checker import rbt_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   // drop ready while a request walks the table
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   a_barrier_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.barrier |-> rsp_data.status == ST_OK)
      else $error("barrier emitted with error status");

   a_no_barrier_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.barrier |->
         rsp_data.barrier_resource == 16'd0 && rsp_data.from_layout == 4'd0 &&
         rsp_data.to_layout == 4'd0 && rsp_data.from_access == 2'd0 &&
         rsp_data.to_access == 2'd0 && rsp_data.from_stages == 8'd0 &&
         rsp_data.to_stages == 8'd0)
      else $error("response without barrier carries nonzero fields");

endmodule

bind resource_barrier_tracker rbt_checker u_rbt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_data  (rsp_port.data)
);
